// File: rtl/core/skvt_pkg.sv
// ----------------------------------------------------------------------------
// skvt_pkg
// Shared types and codes for the small key/value table.
// ----------------------------------------------------------------------------
package skvt_pkg;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_REMOVE = 2'd1;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_FIND   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_DUP  = 2'd1,
		ST_FULL = 2'd2,
		ST_MISS = 2'd3
	} status_t;

	// front -> back
	typedef struct packed {
		logic valid;
		op_t  op;
	} cmd_t;

	// back -> front
	typedef struct packed {
		logic pop;
		logic clearing;
	} back_stat_t;

endpackage

// File: rtl/core/skvt_front.sv
// ----------------------------------------------------------------------------
// skvt_front
// Accepts request words, decodes the kind and holds them in a two-word queue.
// ----------------------------------------------------------------------------
module skvt_front #(
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  logic [1:0]            kind,
	input  logic [KEY_BITS-1:0]   key,
	input  logic [VALUE_BITS-1:0] value,
	output skvt_pkg::cmd_t        cmd,
	output logic [KEY_BITS-1:0]   cmd_key,
	output logic [VALUE_BITS-1:0] cmd_value,
	input  skvt_pkg::back_stat_t  back_stat
);
	import skvt_pkg::*;

	op_t                   op_q  [2];
	logic [KEY_BITS-1:0]   key_q [2];
	logic [VALUE_BITS-1:0] val_q [2];
	logic                  wr_ptr_q;
	logic                  rd_ptr_q;
	logic [1:0]            fill_q;
	logic                  push;
	logic                  pop;
	op_t                   dec_op;

	always_comb begin
		unique case (kind)
			KIND_INSERT: dec_op = OP_INSERT;
			KIND_REMOVE: dec_op = OP_REMOVE;
			default:     dec_op = OP_FIND;
		endcase
	end

	assign req_stall = (fill_q == 2'd2) || back_stat.clearing;
	assign push      = req_valid && !req_stall;
	assign pop       = back_stat.pop;

	assign cmd.valid = (fill_q != 2'd0);
	assign cmd.op    = op_q[rd_ptr_q];
	assign cmd_key   = key_q[rd_ptr_q];
	assign cmd_value = val_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			op_q[wr_ptr_q]  <= dec_op;
			key_q[wr_ptr_q] <= key;
			val_q[wr_ptr_q] <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// File: rtl/core/skvt_back.sv
// ----------------------------------------------------------------------------
// skvt_back
// Clears the entry memory after reset. Scans the entry memory for one queued
// command, then commits the update and loads the response register.
// ----------------------------------------------------------------------------
module skvt_back #(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  skvt_pkg::cmd_t        cmd,
	input  logic [KEY_BITS-1:0]   cmd_key,
	input  logic [VALUE_BITS-1:0] cmd_value,
	output skvt_pkg::back_stat_t  back_stat,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output skvt_pkg::status_t     status,
	output logic [VALUE_BITS-1:0] found_value
);
	import skvt_pkg::*;

	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int ENTRY_W = 1 + KEY_BITS + VALUE_BITS;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

	typedef enum logic [3:0] {
		S_CLEAR  = 4'b0001,
		S_IDLE   = 4'b0010,
		S_SCAN   = 4'b0100,
		S_COMMIT = 4'b1000
	} state_t;

	logic [ENTRY_W-1:0]    mem [ENTRIES];
	logic [ENTRY_W-1:0]    rdata_s1;
	logic                  rd_vld_s1;
	logic [IDX_W-1:0]      rd_idx_s1;

	state_t                state_q;
	logic [IDX_W-1:0]      addr_q;
	logic                  issue_done_q;
	op_t                   op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic                  hit_q;
	logic [IDX_W-1:0]      hit_idx_q;
	logic [VALUE_BITS-1:0] hit_val_q;
	logic                  free_q;
	logic [IDX_W-1:0]      free_idx_q;

	logic                  rsp_valid_q;
	status_t               rsp_status_q;
	logic [VALUE_BITS-1:0] rsp_value_q;

	logic                  can_out;
	logic                  commit;
	logic                  mem_we;
	logic                  mem_re;
	logic [IDX_W-1:0]      mem_addr;
	logic [ENTRY_W-1:0]    mem_wdata;
	status_t               res_status;
	logic [VALUE_BITS-1:0] res_value;
	logic                  rd_entry_valid;
	logic [KEY_BITS-1:0]   rd_entry_key;

	assign rd_entry_valid = rdata_s1[ENTRY_W-1];
	assign rd_entry_key   = rdata_s1[VALUE_BITS +: KEY_BITS];

	assign can_out = !rsp_valid_q || !rsp_stall;
	assign commit  = (state_q == S_COMMIT) && can_out;
	assign mem_re  = (state_q == S_SCAN) && !issue_done_q;

	assign back_stat.pop      = (state_q == S_IDLE) && cmd.valid;
	assign back_stat.clearing = (state_q == S_CLEAR);

	// commit decision
	always_comb begin
		res_status = ST_OK;
		res_value  = '0;
		mem_we     = 1'b0;
		mem_addr   = addr_q;
		mem_wdata  = '0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
			end
			S_COMMIT: begin
				case (op_q)
					OP_INSERT: begin
						if (hit_q) begin
							res_status = ST_DUP;
						end else if (free_q) begin
							mem_we    = commit;
							mem_addr  = free_idx_q;
							mem_wdata = {1'b1, key_q, val_q};
						end else begin
							res_status = ST_FULL;
						end
					end
					OP_REMOVE: begin
						if (hit_q) begin
							mem_we    = commit;
							mem_addr  = hit_idx_q;
							mem_wdata = {1'b0, key_q, val_q};
						end else begin
							res_status = ST_MISS;
						end
					end
					default: begin
						if (hit_q) begin
							res_value = hit_val_q;
						end else begin
							res_status = ST_MISS;
						end
					end
				endcase
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end else if (mem_re) begin
			rdata_s1 <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (back_stat.pop) begin
			op_q  <= cmd.op;
			key_q <= cmd_key;
			val_q <= cmd_value;
		end
		if (rd_vld_s1 && rd_entry_valid && (rd_entry_key == key_q) && !hit_q) begin
			hit_idx_q <= rd_idx_s1;
			hit_val_q <= rdata_s1[VALUE_BITS-1:0];
		end
		if (rd_vld_s1 && !rd_entry_valid && !free_q) begin
			free_idx_q <= rd_idx_s1;
		end
		if (commit) begin
			rsp_status_q <= res_status;
			rsp_value_q  <= res_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			addr_q       <= '0;
			issue_done_q <= 1'b0;
			rd_vld_s1    <= 1'b0;
			rd_idx_s1    <= '0;
			hit_q        <= 1'b0;
			free_q       <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (commit) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					addr_q <= addr_q + IDX_W'(1);
					if (addr_q == LAST) state_q <= S_IDLE;
				end
				S_IDLE: begin
					addr_q       <= '0;
					issue_done_q <= 1'b0;
					rd_vld_s1    <= 1'b0;
					hit_q        <= 1'b0;
					free_q       <= 1'b0;
					if (cmd.valid) state_q <= S_SCAN;
				end
				S_SCAN: begin
					rd_vld_s1 <= mem_re;
					if (mem_re) begin
						rd_idx_s1 <= addr_q;
						addr_q    <= addr_q + IDX_W'(1);
						if (addr_q == LAST) issue_done_q <= 1'b1;
					end
					if (rd_vld_s1 && rd_entry_valid && (rd_entry_key == key_q)) hit_q <= 1'b1;
					if (rd_vld_s1 && !rd_entry_valid) free_q <= 1'b1;
					if (rd_vld_s1 && (rd_idx_s1 == LAST)) state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					rd_vld_s1 <= 1'b0;
					if (can_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_CLEAR;
			endcase
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = rsp_status_q;
	assign found_value = rsp_value_q;

`ifndef SYNTHESIS
	a_last_read_commits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && rd_vld_s1 && rd_idx_s1 == LAST) |=> (state_q == S_COMMIT))
		else $error("scan did not end after last entry");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && op_q == OP_FIND && !hit_q) |=> (status == ST_MISS && found_value == '0))
		else $error("find miss response wrong");

	a_insert_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && op_q == OP_INSERT && !hit_q && free_q) |=> (rsp_valid && status == ST_OK))
		else $error("insert into free entry not reported ok");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_COMMIT) |-> !back_stat.pop)
		else $error("queue popped while a command is in flight");
`endif

endmodule

// File: rtl/core/small_key_value_table_unit.sv
// ----------------------------------------------------------------------------
// small_key_value_table_unit
// Linear search key/value table: insert, remove and find over a one-port
// entry memory, with a decoupled request queue and a registered response.
//
//  channel  | handshake            | fields
//  request  | req_valid, req_stall | kind, key, value
//  response | rsp_valid, rsp_stall | status, found_value
//
// Each word is loaded from the queue, then scanned through the entry memory
// read port, and committed once the response register is free.
// After reset a clearing pass over every entry holds req_stall high.
// The request queue holds two words, so the next words are taken while a
// command is scanned or a response waits on rsp_stall.
// ----------------------------------------------------------------------------
module small_key_value_table_unit #(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  logic [1:0]            kind,
	input  logic [KEY_BITS-1:0]   key,
	input  logic [VALUE_BITS-1:0] value,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output skvt_pkg::status_t     status,
	output logic [VALUE_BITS-1:0] found_value
);
	import skvt_pkg::*;

	cmd_t                  cmd;
	back_stat_t            back_stat;
	logic [KEY_BITS-1:0]   cmd_key;
	logic [VALUE_BITS-1:0] cmd_value;

	skvt_front #(
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.kind      (kind),
		.key       (key),
		.value     (value),
		.cmd       (cmd),
		.cmd_key   (cmd_key),
		.cmd_value (cmd_value),
		.back_stat (back_stat)
	);

	skvt_back #(
		.ENTRIES    (ENTRIES),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cmd_key     (cmd_key),
		.cmd_value   (cmd_value),
		.back_stat   (back_stat),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.found_value (found_value)
	);

endmodule

// File: dv/small_key_value_table_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// small_key_value_table_unit_tb
// Self-checking bench for the linear search key/value table. A shadow copy
// of the table predicts status and found_value for every accepted request
// word. Directed tests cover the empty table, filling to full, duplicates,
// removal and slot reuse, and the spare kind code. Random rounds with a
// small key pool follow, with random gaps on both channels.
// ----------------------------------------------------------------------------
module small_key_value_table_unit_tb;
	import skvt_pkg::*;

	localparam int ENTRIES    = 16;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 32;
	localparam int POOL_SIZE  = 24;
	localparam logic [1:0] KIND_SPARE = 2'd3;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  req_valid = 1'b0;
	logic [1:0]            kind      = OP_FIND;
	logic [KEY_BITS-1:0]   key       = '0;
	logic [VALUE_BITS-1:0] value     = '0;
	logic                  rsp_stall = 1'b0;
	logic                  req_stall;
	logic                  rsp_valid;
	status_t               status;
	logic [VALUE_BITS-1:0] found_value;

	typedef struct {
		status_t               status;
		logic [VALUE_BITS-1:0] found_value;
	} answer_t;

	answer_t               answer_q[$];
	bit                    shadow_used[ENTRIES];
	logic [KEY_BITS-1:0]   shadow_key[ENTRIES];
	logic [VALUE_BITS-1:0] shadow_val[ENTRIES];
	logic [KEY_BITS-1:0]   key_pool[POOL_SIZE];

	int  errors    = 0;
	int  checked   = 0;
	int  n_kind[4] = '{default: 0};
	int  n_stat[4] = '{default: 0};
	bit  no_idle   = 1'b0;
	int  stall_hold = 0;

	small_key_value_table_unit #(
		.ENTRIES(ENTRIES),
		.KEY_BITS(KEY_BITS),
		.VALUE_BITS(VALUE_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.kind(kind),
		.key(key),
		.value(value),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status(status),
		.found_value(found_value)
	);

	initial forever #1 clk = ~clk;

	initial begin
		#2_000_000;
		$display("timeout: %0d responses still outstanding", answer_q.size());
		$display("DONE: errors detected");
		$finish;
	end

	// shadow table: applies one request and returns the response it causes
	function automatic answer_t table_apply(input logic [1:0] k, input logic [KEY_BITS-1:0] kk,
		input logic [VALUE_BITS-1:0] v);
		answer_t a;
		int      hit;
		int      slot;
		a.status      = ST_OK;
		a.found_value = '0;
		hit           = ENTRIES;
		slot          = ENTRIES;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (shadow_used[i] && shadow_key[i] == kk)
				hit = i;
			if (!shadow_used[i])
				slot = i;
		end
		if (k == OP_FIND || k == KIND_SPARE) begin
			if (hit < ENTRIES)
				a.found_value = shadow_val[hit];
			else
				a.status = ST_MISS;
		end else if (k == OP_REMOVE) begin
			if (hit < ENTRIES)
				shadow_used[hit] = 1'b0;
			else
				a.status = ST_MISS;
		end else if (hit < ENTRIES) begin
			a.status = ST_DUP;
		end else if (slot < ENTRIES) begin
			shadow_used[slot] = 1'b1;
			shadow_key[slot]  = kk;
			shadow_val[slot]  = v;
		end else begin
			a.status = ST_FULL;
		end
		return a;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	task automatic note_error(input string msg);
		if (errors < 10)
			$display("ERROR @%0t: %s", $realtime, msg);
		errors++;
	endtask

	task automatic send_word(input logic [1:0] k, input logic [KEY_BITS-1:0] kk,
		input logic [VALUE_BITS-1:0] v);
		answer_t a;
		int      gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		kind      <= k;
		key       <= kk;
		value     <= v;
		do @(posedge clk); while (req_stall);
		a = table_apply(k, kk, v);
		answer_q.push_back(a);
		n_kind[k]++;
		n_stat[a.status]++;
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (answer_q.size() != 0) @(posedge clk);
	endtask

	// response side: check each accepted word, drive random stall
	always @(posedge clk) begin : rsp_side
		answer_t want;
		int      r;
		if (rsp_valid && !rsp_stall) begin
			if (answer_q.size() == 0) begin
				note_error($sformatf("unexpected response status=%0d found_value=%h",
					status, found_value));
			end else begin
				want = answer_q.pop_front();
				checked++;
				if (status !== want.status || found_value !== want.found_value)
					note_error($sformatf("status exp %0d got %0d, found_value exp %h got %h",
						want.status, status, want.found_value, found_value));
			end
		end
		if (no_idle) begin
			rsp_stall  <= 1'b0;
			stall_hold = 0;
		end else if (stall_hold > 0) begin
			stall_hold--;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				rsp_stall  <= 1'b0;
				stall_hold = $urandom_range(0, 7);
			end else if (r < 90) begin
				rsp_stall  <= 1'b1;
				stall_hold = $urandom_range(0, 2);
			end else if (r < 98) begin
				rsp_stall  <= 1'b1;
				stall_hold = $urandom_range(3, 9);
			end else begin
				rsp_stall  <= 1'b1;
				stall_hold = $urandom_range(19, 39);
			end
		end
	end

	task automatic test_empty_table();
		send_word(OP_FIND, '0, '1);
		send_word(OP_REMOVE, '1, '0);
		send_word(KIND_SPARE, 32'h1234_5678, 32'h0);
	endtask

	task automatic test_fill_to_full();
		logic [KEY_BITS-1:0]   kk;
		logic [VALUE_BITS-1:0] v;
		for (int i = 0; i < ENTRIES; i++) begin
			kk = (i == 1) ? '1 : KEY_BITS'(i) * 32'h1111_0101;
			v  = (i == 0) ? '1 : (i == 1) ? '0 : VALUE_BITS'($urandom);
			send_word(OP_INSERT, kk, v);
		end
		send_word(OP_INSERT, 32'hdead_0001, 32'h5a5a_5a5a);
		send_word(OP_INSERT, '0, 32'h0bad_0bad);
		send_word(OP_FIND, '0, '0);
		send_word(KIND_SPARE, '1, '1);
	endtask

	task automatic test_remove_reuse();
		send_word(OP_REMOVE, 32'd5 * 32'h1111_0101, '0);
		send_word(OP_FIND, 32'd5 * 32'h1111_0101, '0);
		send_word(OP_REMOVE, 32'd5 * 32'h1111_0101, '0);
		send_word(OP_INSERT, 32'h8000_0000, 32'h5555_aaaa);
		send_word(OP_FIND, 32'h8000_0000, '1);
		send_word(OP_INSERT, 32'h0000_0001, 32'haaaa_5555);
	endtask

	task automatic test_random_round(input int n, input int w_ins, input int w_rem);
		logic [1:0]            k;
		logic [KEY_BITS-1:0]   kk;
		logic [VALUE_BITS-1:0] v;
		int                    r;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < w_ins)
				k = OP_INSERT;
			else if (r < w_ins + w_rem)
				k = OP_REMOVE;
			else
				k = ($urandom_range(0, 4) == 0) ? KIND_SPARE : OP_FIND;
			kk = ($urandom_range(0, 99) < 80) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
				: KEY_BITS'($urandom);
			r = $urandom_range(0, 99);
			v = (r < 10) ? '0 : (r < 20) ? '1 : VALUE_BITS'($urandom);
			send_word(k, kk, v);
		end
	endtask

	initial begin
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			key_pool[i] = KEY_BITS'($urandom);
		for (int i = 0; i < ENTRIES; i++)
			shadow_used[i] = 1'b0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_table();
		wait_drained();
		test_fill_to_full();
		wait_drained();
		test_remove_reuse();
		wait_drained();

		test_random_round(250, 60, 10);
		test_random_round(250, 20, 60);
		wait_drained();
		no_idle = 1'b1;
		test_random_round(250, 34, 33);
		no_idle = 1'b0;
		test_random_round(250, 50, 20);
		wait_drained();
		test_random_round(250, 10, 70);
		test_random_round(250, 40, 30);
		test_random_round(250, 45, 25);
		wait_drained();
		repeat (ENTRIES + 23) @(posedge clk);

		$display("Run: %0d insert, %0d remove, %0d find, %0d spare-code find; %0d words checked",
			n_kind[OP_INSERT], n_kind[OP_REMOVE], n_kind[OP_FIND], n_kind[KIND_SPARE], checked);
		$display("Outcomes: ok %0d, duplicate %0d, full %0d, miss %0d; %0d mismatches",
			n_stat[ST_OK], n_stat[ST_DUP], n_stat[ST_FULL], n_stat[ST_MISS], errors);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
